FILE: hdl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Triangle circumcircle package
// Widths, constants and the item type carried between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  localparam int COORD_BITS = 24;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int HD_W   = PROD_W + 1;
  localparam int SQ_W   = PROD_W;
  localparam int LO_W   = DIFF_W;
  localparam int HI_W   = SQ_W - LO_W;
  localparam int PP_W   = LO_W + 1 + DIFF_W;
  localparam int BC_W   = SQ_W + DIFF_W + 1;
  localparam int NUM_W  = BC_W + 1;
  localparam int NMAG_W = NUM_W - 1;
  localparam int DMAG_W = HD_W + 1;
  localparam int REM_W  = NMAG_W + 2;
  localparam int DD_W   = DMAG_W + 1;
  localparam int CAP_SH = 34;
  localparam int QBITS  = CAP_SH + 1;
  localparam int CMP_W  = DD_W + QBITS;
  localparam int UX_W   = QBITS + 1;
  localparam int PX_W   = UX_W + 1;
  localparam int S_W    = 2 * COORD_BITS + 1;
  localparam int ROOT_W = COORD_BITS + 1;
  localparam int TSQ_W  = 2 * ROOT_W + 1;
  localparam int RAD_W  = ROOT_W + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [HD_W-1:0]       hd_t;
  typedef logic        [SQ_W-1:0]       sq_t;
  typedef logic signed [PP_W-1:0]       pp_t;
  typedef logic signed [BC_W-1:0]       bc_t;
  typedef logic signed [NUM_W-1:0]      num_t;

  localparam logic [QBITS-1:0] CAP_MAG = QBITS'(1) << CAP_SH;
  localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [NMAG_W-1:0] nx_mag;
    logic [NMAG_W-1:0] ny_mag;
    logic              neg_x;
    logic              neg_y;
    logic [DMAG_W-1:0] dmag;
    coord_t            ax;
    coord_t            ay;
    logic              deg;
  } qitem_t;

endpackage

`default_nettype wire

FILE: hdl/tcc_if.sv
// ----------------------------------------------------------------------------
// Triangle circumcircle channels
// Valid/ready channels for the vertex items and the circle result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_in_if import tcc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex_a_x;
  coord_t vertex_a_y;
  coord_t vertex_b_x;
  coord_t vertex_b_y;
  coord_t vertex_c_x;
  coord_t vertex_c_y;

  modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, input ready);
  modport sink (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                vertex_c_x, vertex_c_y, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  coord_t                center_x;
  coord_t                center_y;
  logic [COORD_BITS-1:0] radius;
  logic                  degenerate;
  logic                  saturated;

  modport source (output valid, center_x, center_y, radius, degenerate, saturated,
                  input ready);
  modport sink (input valid, center_x, center_y, radius, degenerate, saturated,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/tcc_front.sv
// ----------------------------------------------------------------------------
// Triangle circumcircle front part
// Accepts vertex items, forms the determinant and both numerators, and classifies
// the collinear case before handing the item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_front import tcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  tcc_in_if.sink    in_ch,
  output logic      push_valid,
  output qitem_t    push_item,
  input  wire logic push_ready
);

  localparam int NF = 7;

  logic [NF-1:0] v_r;
  logic          en;

  coord_t ax1_r, ay1_r;
  diff_t  bx1_r, by1_r, cx1_r, cy1_r;

  coord_t ax2_r, ay2_r;
  diff_t  bx2_r, by2_r, cx2_r, cy2_r;
  prod_t  bxcy2_r, bycx2_r, bxx2_r, byy2_r, cxx2_r, cyy2_r;

  coord_t ax3_r, ay3_r;
  diff_t  bx3_r, by3_r, cx3_r, cy3_r;
  hd_t    hd3_r;
  sq_t    bb3_r, cc3_r;

  coord_t ax4_r, ay4_r;
  hd_t    hd4_r;
  pp_t    bbl_cy4_r, bbh_cy4_r, ccl_by4_r, cch_by4_r;
  pp_t    ccl_bx4_r, cch_bx4_r, bbl_cx4_r, bbh_cx4_r;

  coord_t ax5_r, ay5_r;
  hd_t    hd5_r;
  bc_t    bcy5_r, cby5_r, cbx5_r, bcx5_r;

  coord_t ax6_r, ay6_r;
  hd_t    hd6_r;
  num_t   nx6_r, ny6_r;

  qitem_t     item7_r;
  logic [HD_W-1:0] hmag6;

  assign en          = !v_r[NF-1] || push_ready;
  assign in_ch.ready = en;
  assign push_valid  = v_r[NF-1];
  assign push_item   = item7_r;
  assign hmag6       = hd6_r[HD_W-1] ? HD_W'(-hd6_r) : HD_W'(hd6_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NF-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= in_ch.vertex_a_x;
      ay1_r <= in_ch.vertex_a_y;
      bx1_r <= diff_t'(in_ch.vertex_b_x) - diff_t'(in_ch.vertex_a_x);
      by1_r <= diff_t'(in_ch.vertex_b_y) - diff_t'(in_ch.vertex_a_y);
      cx1_r <= diff_t'(in_ch.vertex_c_x) - diff_t'(in_ch.vertex_a_x);
      cy1_r <= diff_t'(in_ch.vertex_c_y) - diff_t'(in_ch.vertex_a_y);

      ax2_r   <= ax1_r;
      ay2_r   <= ay1_r;
      bx2_r   <= bx1_r;
      by2_r   <= by1_r;
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
      bxcy2_r <= prod_t'(bx1_r) * prod_t'(cy1_r);
      bycx2_r <= prod_t'(by1_r) * prod_t'(cx1_r);
      bxx2_r  <= prod_t'(bx1_r) * prod_t'(bx1_r);
      byy2_r  <= prod_t'(by1_r) * prod_t'(by1_r);
      cxx2_r  <= prod_t'(cx1_r) * prod_t'(cx1_r);
      cyy2_r  <= prod_t'(cy1_r) * prod_t'(cy1_r);

      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      bx3_r <= bx2_r;
      by3_r <= by2_r;
      cx3_r <= cx2_r;
      cy3_r <= cy2_r;
      hd3_r <= hd_t'(bxcy2_r) - hd_t'(bycx2_r);
      bb3_r <= sq_t'(bxx2_r) + sq_t'(byy2_r);
      cc3_r <= sq_t'(cxx2_r) + sq_t'(cyy2_r);

      ax4_r     <= ax3_r;
      ay4_r     <= ay3_r;
      hd4_r     <= hd3_r;
      bbl_cy4_r <= pp_t'($signed({1'b0, bb3_r[LO_W-1:0]})) * pp_t'(cy3_r);
      bbh_cy4_r <= pp_t'($signed({1'b0, bb3_r[SQ_W-1:LO_W]})) * pp_t'(cy3_r);
      ccl_by4_r <= pp_t'($signed({1'b0, cc3_r[LO_W-1:0]})) * pp_t'(by3_r);
      cch_by4_r <= pp_t'($signed({1'b0, cc3_r[SQ_W-1:LO_W]})) * pp_t'(by3_r);
      ccl_bx4_r <= pp_t'($signed({1'b0, cc3_r[LO_W-1:0]})) * pp_t'(bx3_r);
      cch_bx4_r <= pp_t'($signed({1'b0, cc3_r[SQ_W-1:LO_W]})) * pp_t'(bx3_r);
      bbl_cx4_r <= pp_t'($signed({1'b0, bb3_r[LO_W-1:0]})) * pp_t'(cx3_r);
      bbh_cx4_r <= pp_t'($signed({1'b0, bb3_r[SQ_W-1:LO_W]})) * pp_t'(cx3_r);

      ax5_r  <= ax4_r;
      ay5_r  <= ay4_r;
      hd5_r  <= hd4_r;
      bcy5_r <= (bc_t'(bbh_cy4_r) <<< LO_W) + bc_t'(bbl_cy4_r);
      cby5_r <= (bc_t'(cch_by4_r) <<< LO_W) + bc_t'(ccl_by4_r);
      cbx5_r <= (bc_t'(cch_bx4_r) <<< LO_W) + bc_t'(ccl_bx4_r);
      bcx5_r <= (bc_t'(bbh_cx4_r) <<< LO_W) + bc_t'(bbl_cx4_r);

      ax6_r <= ax5_r;
      ay6_r <= ay5_r;
      hd6_r <= hd5_r;
      nx6_r <= num_t'(bcy5_r) - num_t'(cby5_r);
      ny6_r <= num_t'(cbx5_r) - num_t'(bcx5_r);

      item7_r.nx_mag <= nx6_r[NUM_W-1] ? NMAG_W'(-nx6_r) : NMAG_W'(nx6_r);
      item7_r.ny_mag <= ny6_r[NUM_W-1] ? NMAG_W'(-ny6_r) : NMAG_W'(ny6_r);
      item7_r.neg_x  <= nx6_r[NUM_W-1] ^ hd6_r[HD_W-1];
      item7_r.neg_y  <= ny6_r[NUM_W-1] ^ hd6_r[HD_W-1];
      item7_r.dmag   <= {hmag6, 1'b0};
      item7_r.ax     <= ax6_r;
      item7_r.ay     <= ay6_r;
      item7_r.deg    <= (hd6_r == '0);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tcc_queue.sv
// ----------------------------------------------------------------------------
// Triangle circumcircle queue
// Short first-in first-out queue that lets the front and back parts stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_queue import tcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  input  qitem_t    push_item,
  output logic      push_ready,
  output logic      pop_valid,
  output qitem_t    pop_item,
  input  wire logic take
);

  qitem_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign push_ready = cnt_r != (QPTR_W+1)'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = take && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tcc_back.sv
// ----------------------------------------------------------------------------
// Triangle circumcircle back part
// Pipelined rounding dividers for the centre offsets, centre clipping and a
// pipelined square root for the radius, ending in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_back import tcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic pop_valid,
  input  qitem_t    pop_item,
  output logic      take,
  tcc_out_if.source out_ch
);

  localparam int NB = QBITS + ROOT_W + 5;

  typedef struct packed {
    logic [REM_W-1:0] remx;
    logic [REM_W-1:0] remy;
    logic [QBITS-1:0] qx;
    logic [QBITS-1:0] qy;
    logic             capx;
    logic             capy;
    logic [DD_W-1:0]  dd;
    logic             neg_x;
    logic             neg_y;
    coord_t           ax;
    coord_t           ay;
    logic             deg;
  } dstage_t;

  typedef struct packed {
    logic signed [UX_W-1:0] ux;
    logic signed [UX_W-1:0] uy;
    logic [QBITS-1:0]       umx;
    logic [QBITS-1:0]       umy;
    coord_t                 ax;
    coord_t                 ay;
    logic                   deg;
  } p0_t;

  typedef struct packed {
    coord_t                  cx;
    coord_t                  cy;
    logic                    sat;
    logic                    big;
    logic [2*COORD_BITS-1:0] sqx;
    logic [2*COORD_BITS-1:0] sqy;
    logic                    deg;
  } p1_t;

  typedef struct packed {
    logic [S_W-1:0]    s;
    logic [ROOT_W-1:0] r;
    logic [TSQ_W-1:0]  sq;
    coord_t            cx;
    coord_t            cy;
    logic              sat;
    logic              big;
    logic              deg;
  } sstage_t;

  typedef struct packed {
    coord_t                cx;
    coord_t                cy;
    logic [COORD_BITS-1:0] rad;
    logic                  deg;
    logic                  sat;
  } out_t;

  logic [NB-1:0] bv_r;
  logic          en;

  dstage_t dst_r [QBITS+1];
  p0_t     p0_r, p0_nxt;
  p1_t     p1_r, p1_nxt;
  sstage_t sst_r [ROOT_W+1];
  out_t    out_r, out_nxt;

  logic [REM_W-1:0] nx2, ny2;
  logic [DD_W-1:0]  dd0;

  assign en               = !bv_r[NB-1] || out_ch.ready;
  assign take             = en && pop_valid;
  assign out_ch.valid     = bv_r[NB-1];
  assign out_ch.center_x  = out_r.cx;
  assign out_ch.center_y  = out_r.cy;
  assign out_ch.radius    = out_r.rad;
  assign out_ch.degenerate = out_r.deg;
  assign out_ch.saturated = out_r.sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (en) begin
      bv_r <= {bv_r[NB-2:0], pop_valid};
    end
  end

  // Rounded quotient: (2|num| + |den|) / (2|den|).
  assign nx2 = {1'b0, pop_item.nx_mag, 1'b0} + REM_W'(pop_item.dmag);
  assign ny2 = {1'b0, pop_item.ny_mag, 1'b0} + REM_W'(pop_item.dmag);
  assign dd0 = {pop_item.dmag, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      dst_r[0].remx  <= nx2;
      dst_r[0].remy  <= ny2;
      dst_r[0].qx    <= '0;
      dst_r[0].qy    <= '0;
      dst_r[0].capx  <= CMP_W'(nx2) >= {dd0, {QBITS{1'b0}}};
      dst_r[0].capy  <= CMP_W'(ny2) >= {dd0, {QBITS{1'b0}}};
      dst_r[0].dd    <= dd0;
      dst_r[0].neg_x <= pop_item.neg_x;
      dst_r[0].neg_y <= pop_item.neg_y;
      dst_r[0].ax    <= pop_item.ax;
      dst_r[0].ay    <= pop_item.ay;
      dst_r[0].deg   <= pop_item.deg;
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_div
    localparam int BI = QBITS - k;
    logic [CMP_W-1:0] tr;
    logic             gex, gey;
    dstage_t          d_nxt;

    assign tr  = CMP_W'(dst_r[k-1].dd) << BI;
    assign gex = CMP_W'(dst_r[k-1].remx) >= tr;
    assign gey = CMP_W'(dst_r[k-1].remy) >= tr;

    always_comb begin
      d_nxt = dst_r[k-1];
      if (gex) begin
        d_nxt.remx   = dst_r[k-1].remx - tr[REM_W-1:0];
        d_nxt.qx[BI] = 1'b1;
      end
      if (gey) begin
        d_nxt.remy   = dst_r[k-1].remy - tr[REM_W-1:0];
        d_nxt.qy[BI] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dst_r[k] <= d_nxt;
      end
    end
  end

  always_comb begin
    logic [QBITS-1:0] mx, my;
    mx = (dst_r[QBITS].capx || dst_r[QBITS].qx > CAP_MAG) ? CAP_MAG : dst_r[QBITS].qx;
    my = (dst_r[QBITS].capy || dst_r[QBITS].qy > CAP_MAG) ? CAP_MAG : dst_r[QBITS].qy;
    p0_nxt.umx = mx;
    p0_nxt.umy = my;
    p0_nxt.ux  = (dst_r[QBITS].neg_x && mx != '0) ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
    p0_nxt.uy  = (dst_r[QBITS].neg_y && my != '0) ? -$signed({1'b0, my}) : $signed({1'b0, my});
    p0_nxt.ax  = dst_r[QBITS].ax;
    p0_nxt.ay  = dst_r[QBITS].ay;
    p0_nxt.deg = dst_r[QBITS].deg;
  end

  always_comb begin
    logic signed [PX_W-1:0] px, py;
    px = PX_W'(p0_r.ax) + PX_W'(p0_r.ux);
    py = PX_W'(p0_r.ay) + PX_W'(p0_r.uy);
    p1_nxt.sat = 1'b0;
    p1_nxt.cx  = px[COORD_BITS-1:0];
    p1_nxt.cy  = py[COORD_BITS-1:0];
    if (px > PX_W'(C_MAX)) begin
      p1_nxt.cx  = C_MAX;
      p1_nxt.sat = 1'b1;
    end else if (px < PX_W'(C_MIN)) begin
      p1_nxt.cx  = C_MIN;
      p1_nxt.sat = 1'b1;
    end
    if (py > PX_W'(C_MAX)) begin
      p1_nxt.cy  = C_MAX;
      p1_nxt.sat = 1'b1;
    end else if (py < PX_W'(C_MIN)) begin
      p1_nxt.cy  = C_MIN;
      p1_nxt.sat = 1'b1;
    end
    // An offset of 2^COORD_BITS or more always clips the radius.
    p1_nxt.big = (p0_r.umx[QBITS-1:COORD_BITS] != '0) || (p0_r.umy[QBITS-1:COORD_BITS] != '0);
    p1_nxt.sqx = p0_r.umx[COORD_BITS-1:0] * p0_r.umx[COORD_BITS-1:0];
    p1_nxt.sqy = p0_r.umy[COORD_BITS-1:0] * p0_r.umy[COORD_BITS-1:0];
    p1_nxt.deg = p0_r.deg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      sst_r[0].s   <= S_W'(p1_r.sqx) + S_W'(p1_r.sqy);
      sst_r[0].r   <= '0;
      sst_r[0].sq  <= '0;
      sst_r[0].cx  <= p1_r.cx;
      sst_r[0].cy  <= p1_r.cy;
      sst_r[0].sat <= p1_r.sat;
      sst_r[0].big <= p1_r.big;
      sst_r[0].deg <= p1_r.deg;
    end
  end

  for (genvar j = 1; j <= ROOT_W; j++) begin : g_sqrt
    localparam int BI = ROOT_W - j;
    logic [TSQ_W-1:0] tsq;
    logic             ge;
    sstage_t          s_nxt;

    assign tsq = sst_r[j-1].sq + (TSQ_W'(sst_r[j-1].r) << (BI + 1))
                 + (TSQ_W'(1) << (2 * BI));
    assign ge  = tsq <= TSQ_W'(sst_r[j-1].s);

    always_comb begin
      s_nxt = sst_r[j-1];
      if (ge) begin
        s_nxt.r[BI] = 1'b1;
        s_nxt.sq    = tsq;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sst_r[j] <= s_nxt;
      end
    end
  end

  always_comb begin
    logic [TSQ_W-1:0] rest;
    logic [RAD_W-1:0] rad;
    logic             up, rsat;
    rest = TSQ_W'(sst_r[ROOT_W].s) - sst_r[ROOT_W].sq;
    up   = rest > TSQ_W'(sst_r[ROOT_W].r);
    rad  = RAD_W'(sst_r[ROOT_W].r) + RAD_W'(up);
    rsat = sst_r[ROOT_W].big || (rad[RAD_W-1:COORD_BITS] != '0);
    if (sst_r[ROOT_W].deg) begin
      out_nxt = '0;
      out_nxt.deg = 1'b1;
    end else begin
      out_nxt.cx  = sst_r[ROOT_W].cx;
      out_nxt.cy  = sst_r[ROOT_W].cy;
      out_nxt.rad = rsat ? '1 : rad[COORD_BITS-1:0];
      out_nxt.deg = 1'b0;
      out_nxt.sat = sst_r[ROOT_W].sat || rsat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/triangle_circumcircle.sv
// Throughput: one item per cycle while the result channel is ready, set by the
// fully pipelined dividers and square root.
// The 35-stage divider pipeline and the 25-stage square-root pipeline set the latency.
// Reset is synchronous and active low; it clears the valid bits and the queue pointers.
// No clearing pass is needed; the block takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
// Triangle circumcircle
// Circumcentre and radius of a triangle in signed fixed point, with collinear
// detection and saturation of results that fall outside the coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumcircle import tcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  tcc_in_if.sink    in_ch,
  tcc_out_if.source out_ch
);

  logic   push_valid, push_ready;
  qitem_t push_item;
  logic   pop_valid, take;
  qitem_t pop_item;

  tcc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  tcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .take       (take)
  );

  tcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .take      (take),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: hdl/tcc_checker.sv
// ----------------------------------------------------------------------------
// Triangle circumcircle checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_checker import tcc_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [COORD_BITS-1:0] center_x,
  input wire logic [COORD_BITS-1:0] center_y,
  input wire logic [COORD_BITS-1:0] radius,
  input wire logic                  degenerate,
  input wire logic                  saturated
);

  logic [7:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({center_x, center_y, radius, degenerate, saturated}))
    else $error("result item changed while stalled");

  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> center_x == '0 && center_y == '0 && radius == '0
      && !saturated)
    else $error("collinear item with nonzero results");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result offered with no item in flight");

endmodule

bind triangle_circumcircle tcc_checker u_tcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .center_x   (out_ch.center_x),
  .center_y   (out_ch.center_y),
  .radius     (out_ch.radius),
  .degenerate (out_ch.degenerate),
  .saturated  (out_ch.saturated)
);

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Triangle circumcircle testbench
// Streams directed and random triangles through the block with bursty input
// and a stalling receiver, and checks every result against a bit-exact
// predictor of the circumcentre, radius and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tcc_pkg::*;

  localparam int     LATENCY   = 72;
  localparam int     N_RANDOM  = 1430;
  localparam longint CYC_LIMIT = 600000;
  localparam longint CRD_MAX   = 64'sd8388607;
  localparam longint CRD_MIN   = -64'sd8388608;

  typedef logic signed [127:0] wide_t;
  typedef logic        [127:0] uwide_t;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy;
  } triangle_t;

  typedef struct packed {
    coord_t                cen_x;
    coord_t                cen_y;
    logic [COORD_BITS-1:0] radius;
    logic                  degenerate;
    logic                  saturated;
  } circle_t;

  function automatic wide_t rounded_quotient(wide_t num, wide_t den);
    uwide_t nm, dm, q;
    wide_t  res;
    nm  = (num < 0) ? -num : num;
    dm  = (den < 0) ? -den : den;
    q   = (2 * nm + dm) / (2 * dm);
    if (q > (uwide_t'(1) << CAP_SH)) q = uwide_t'(1) << CAP_SH;
    res = q;
    if (((num < 0) != (den < 0)) && q != 0) res = -res;
    return res;
  endfunction

  function automatic circle_t circumcircle_of(triangle_t t);
    wide_t   ax, ay, bx, by, cx, cy, den, bb, cc, ux, uy, px, py;
    uwide_t  s, r, trial;
    circle_t c;
    c  = '0;
    ax = t.ax;
    ay = t.ay;
    bx = t.bx;
    by = t.by;
    cx = t.cx;
    cy = t.cy;
    bx = bx - ax;
    by = by - ay;
    cx = cx - ax;
    cy = cy - ay;
    den = bx * cy - by * cx;
    if (den == 0) begin
      c.degenerate = 1'b1;
      return c;
    end
    den = den * 2;
    bb  = bx * bx + by * by;
    cc  = cx * cx + cy * cy;
    ux  = rounded_quotient(cy * bb - by * cc, den);
    uy  = rounded_quotient(bx * cc - cx * bb, den);
    px  = ax + ux;
    py  = ay + uy;
    if (px > CRD_MAX) begin px = CRD_MAX; c.saturated = 1'b1; end
    if (px < CRD_MIN) begin px = CRD_MIN; c.saturated = 1'b1; end
    if (py > CRD_MAX) begin py = CRD_MAX; c.saturated = 1'b1; end
    if (py < CRD_MIN) begin py = CRD_MIN; c.saturated = 1'b1; end
    s = ux * ux + uy * uy;
    r = 0;
    for (int b = 35; b >= 0; b--) begin
      trial = r | (uwide_t'(1) << b);
      if (trial * trial <= s) r = trial;
    end
    if (s - r * r > r) r = r + 1;
    if (r > uwide_t'(24'hFFFFFF)) begin
      r = 24'hFFFFFF;
      c.saturated = 1'b1;
    end
    c.cen_x  = px[COORD_BITS-1:0];
    c.cen_y  = py[COORD_BITS-1:0];
    c.radius = r[COORD_BITS-1:0];
    return c;
  endfunction

  class circle_scoreboard;
    circle_t pending_circles[$];
    int      errors;

    function void note_triangle(triangle_t t);
      pending_circles.push_back(circumcircle_of(t));
    endfunction

    function void check_circle(circle_t got);
      circle_t want;
      if (pending_circles.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result item: %p", got);
        return;
      end
      want = pending_circles.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected x=%0d y=%0d r=%0d deg=%0b sat=%0b,",
                   want.cen_x, want.cen_y, want.radius, want.degenerate, want.saturated,
                   " got x=%0d y=%0d r=%0d deg=%0b sat=%0b",
                   got.cen_x, got.cen_y, got.radius, got.degenerate, got.saturated);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  longint cycles = 0;
  circle_scoreboard board;

  tcc_in_if  in_ch ();
  tcc_out_if out_ch ();

  triangle_circumcircle dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial board = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_triangle('{in_ch.vertex_a_x, in_ch.vertex_a_y, in_ch.vertex_b_x,
                            in_ch.vertex_b_y, in_ch.vertex_c_x, in_ch.vertex_c_y});
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_circle('{out_ch.center_x, out_ch.center_y, out_ch.radius,
                           out_ch.degenerate, out_ch.saturated});
  end

  // The receiver steps through four ready patterns in turn.
  int stall_phase;
  always @(negedge clk) begin
    stall_phase = int'((cycles / 400) % 4);
    case (stall_phase)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 99) < 70);
      2: out_ch.ready <= ((cycles % 23) < 12);
      default: out_ch.ready <= ($urandom_range(0, 99) < 20);
    endcase
  end

  function automatic coord_t rand_coord();
    return coord_t'($urandom());
  endfunction

  function automatic coord_t near(coord_t base, int span);
    return base + coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return '1;
      default: return coord_t'(1);
    endcase
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    int        kind, span, m;
    coord_t    ox, oy;
    kind = $urandom_range(0, 99);
    span = 1 << $urandom_range(1, 14);
    ox   = coord_t'($urandom_range(0, 1 << 23)) - coord_t'(1 << 22);
    oy   = coord_t'($urandom_range(0, 1 << 23)) - coord_t'(1 << 22);
    if (kind < 55) begin
      t = '{near(ox, span), near(oy, span), near(ox, span), near(oy, span),
            near(ox, span), near(oy, span)};
    end else if (kind < 70) begin
      t = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord()};
    end else if (kind < 80) begin
      t.ax = near(ox, span);
      t.ay = near(oy, span);
      t.bx = near(ox, span);
      t.by = near(oy, span);
      m    = $urandom_range(0, 6) - 3;
      t.cx = t.ax + coord_t'(m) * (t.bx - t.ax);
      t.cy = t.ay + coord_t'(m) * (t.by - t.ay);
    end else if (kind < 90) begin
      t.ax = rand_coord();
      t.ay = rand_coord();
      t.bx = rand_coord();
      t.by = rand_coord();
      t.cx = near(t.bx, 2);
      t.cy = near(t.by, 2);
    end else begin
      t = '{pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
            pick_extreme(), pick_extreme()};
    end
    return t;
  endfunction

  task automatic send_triangle(triangle_t t);
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.vertex_a_x = t.ax;
    in_ch.vertex_a_y = t.ay;
    in_ch.vertex_b_x = t.bx;
    in_ch.vertex_b_y = t.by;
    in_ch.vertex_c_x = t.cx;
    in_ch.vertex_c_y = t.cy;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_sender(int gap);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain_results();
    while (board.pending_circles.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  triangle_t directed[$];
  int        burst_left;

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.vertex_a_x = '0;
    in_ch.vertex_a_y = '0;
    in_ch.vertex_b_x = '0;
    in_ch.vertex_b_y = '0;
    in_ch.vertex_c_x = '0;
    in_ch.vertex_c_y = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed = '{
      '{24'sd0, 24'sd0, 24'sd256, 24'sd0, 24'sd0, 24'sd256},
      '{24'sd0, 24'sd0, 24'sd0, 24'sd256, 24'sd256, 24'sd0},
      '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd9, 24'sd1},
      '{24'sd0, 24'sd0, 24'sd100, 24'sd100, 24'sd300, 24'sd300},
      '{24'sd100, 24'sd0, 24'sd100, 24'sd500, 24'sd400, 24'sd200},
      '{24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd1},
      '{24'sd0, 24'sd0, 24'sd3, 24'sd0, 24'sd0, 24'sd3},
      '{C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX},
      '{C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN},
      '{C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN},
      '{C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX - 24'sd1},
      '{C_MIN, C_MIN, C_MAX, C_MAX, 24'sd0, 24'sd0},
      '{C_MIN, C_MIN, C_MAX, C_MAX, 24'sd1, 24'sd0},
      '{24'sd0, 24'sd0, C_MAX, 24'sd1, C_MIN, 24'sd1},
      '{C_MAX, 24'sd0, C_MAX, 24'sd10, C_MAX - 24'sd10, 24'sd5},
      '{C_MIN, 24'sd0, C_MIN, 24'sd10, C_MIN + 24'sd10, 24'sd5},
      '{-24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd0, 24'sd1},
      '{24'sd1000, 24'sd2000, -24'sd3000, 24'sd500, 24'sd700, -24'sd4000},
      '{24'sd0, 24'sd0, 24'sd2, 24'sd1, 24'sd1, 24'sd2},
      '{24'sd0, 24'sd0, 24'sd4000000, 24'sd1, 24'sd8000000, 24'sd3}
    };
    foreach (directed[i]) send_triangle(directed[i]);
    pause_sender(3);

    burst_left = $urandom_range(1, 40);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        pause_sender(0);
        drain_results();
      end
      send_triangle(random_triangle());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 15));
      end
    end
    pause_sender(0);
    drain_results();

    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
